FILE: rtl/core/rls_pkg.sv
`default_nettype none

package rls_pkg;

    // Chain geometry.
    localparam int RLS_LED_COUNT = 10;
    localparam int BYTES_PER_LED = 3;
    localparam int ROW_W         = 8 * BYTES_PER_LED;

    // Item field widths.
    localparam int OP_W     = 3;
    localparam int INDEX_W  = 8;
    localparam int COLOR_W  = 24;
    localparam int STATUS_W = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_SET_PIXEL = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_SIDE  = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd2;
    localparam logic [OP_W-1:0] OP_START     = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK      = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY      = 2'd2;

    // Configuration port and register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH      = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic exec_pixel;
        logic side_init;
        logic side_step;
        logic clear;
        logic snap_init;
        logic snap_step;
        logic frame_start;
        logic tick;
        logic refuse;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sending;
        logic            row_last;
    } t_stat;

endpackage

`default_nettype wire

FILE: rtl/core/rls_if.sv
`default_nettype none

// Input channel: one operation word.
interface rls_item_if;
    import rls_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [INDEX_W-1:0]   led_index;
    logic [COLOR_W-1:0]   color;
    logic                 side;

    modport source (output valid, output op, output led_index, output color, output side,
                    input ready);
    modport sink   (input valid, input op, input led_index, input color, input side,
                    output ready);
endinterface

// Output channel: one result word per operation.
interface rls_result_if;
    import rls_pkg::*;
    logic                valid;
    logic                ready;
    logic                line;
    logic                busy_res;
    logic                frame_done;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output line, output busy_res, output frame_done,
                    output status, input ready);
    modport sink   (input valid, input line, input busy_res, input frame_done,
                    input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rls_ctrl.sv
`default_nettype none

module rls_ctrl import rls_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SIDE   = 3'd2;
    localparam logic [2:0] S_SNAP   = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FINISH;
                case (i_stat.op)
                    OP_SET_PIXEL: o_cmd.exec_pixel = 1'b1;
                    OP_SET_SIDE: begin
                        o_cmd.side_init = 1'b1;
                        n_state         = S_SIDE;
                    end
                    OP_CLEAR: o_cmd.clear = 1'b1;
                    OP_START: begin
                        if (i_stat.sending) begin
                            o_cmd.refuse = 1'b1;
                        end else begin
                            o_cmd.snap_init = 1'b1;
                            n_state         = S_SNAP;
                        end
                    end
                    OP_TICK: o_cmd.tick = 1'b1;
                    default: ;
                endcase
            end
            S_SIDE: begin
                o_cmd.side_step = 1'b1;
                if (i_stat.row_last) begin
                    n_state = S_FINISH;
                end
            end
            S_SNAP: begin
                o_cmd.snap_step = 1'b1;
                if (i_stat.row_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last scaled row is written during this cycle.
                o_cmd.frame_start = 1'b1;
                n_state           = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output word valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/rls_dp.sv
`default_nettype none

module rls_dp import rls_pkg::*; #(
    parameter int LED_COUNT = RLS_LED_COUNT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [OP_W-1:0]       i_op,
    input  logic [INDEX_W-1:0]    i_led_index,
    input  logic [COLOR_W-1:0]    i_color,
    input  logic                  i_side,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic                  o_line,
    output logic                  o_busy_res,
    output logic                  o_frame_done,
    output logic [STATUS_W-1:0]   o_status
);

    localparam int LED_W    = $clog2(LED_COUNT);
    localparam int HALF     = LED_COUNT / 2;
    localparam int BIT_W    = $clog2(ROW_W);
    localparam logic [LED_W-1:0] LED_LAST   = LED_W'(LED_COUNT - 1);
    localparam logic [LED_W-1:0] RIGHT_LAST = LED_W'(HALF - 1);
    localparam logic [LED_W-1:0] LEFT_FIRST = LED_W'(HALF);
    localparam logic [LED_W-1:0] LEFT_LAST  = LED_W'(2 * HALF - 1);
    localparam logic [BIT_W-1:0] BIT_LAST   = BIT_W'(ROW_W - 1);
    localparam logic [6:0]  PCT_MAX     = 7'd100;
    localparam logic [13:0] SCALE_RECIP = 14'd10486;  // about 2^20 / 100

    // Zero length phases count as one tick.
    function automatic logic [11:0] at_least_one(input logic [11:0] v);
        return (v == 12'd0) ? 12'd1 : v;
    endfunction

    // Video-safe byte scaling: lit bytes stay lit unless the scale is zero.
    function automatic logic [7:0] scale_byte(input logic [7:0] v, input logic [7:0] s);
        logic [15:0] prod;
        prod = v * s;
        return prod[15:8] + 8'((v != 8'd0) && (s != 8'd0));
    endfunction

    // Configuration registers.
    logic [6:0]  r_bright;
    logic [5:0]  r_zero_high, r_zero_low, r_one_high, r_one_low;
    logic [11:0] r_latch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright    <= 7'd100;
            r_zero_high <= 6'd3;
            r_zero_low  <= 6'd9;
            r_one_high  <= 6'd6;
            r_one_low   <= 6'd6;
            r_latch     <= 12'd800;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BRIGHTNESS: r_bright    <= i_cfg_wdata[6:0];
                CFG_ZERO_HIGH:  r_zero_high <= i_cfg_wdata[5:0];
                CFG_ZERO_LOW:   r_zero_low  <= i_cfg_wdata[5:0];
                CFG_ONE_HIGH:   r_one_high  <= i_cfg_wdata[5:0];
                CFG_ONE_LOW:    r_one_low   <= i_cfg_wdata[5:0];
                CFG_LATCH:      r_latch     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Brightness scale floor(p*255/100), kept in a register.
    logic [6:0]  pct_sat;
    logic [14:0] pct_255;
    logic [28:0] scale_prod;
    logic [7:0]  r_scale;

    assign pct_sat    = (r_bright > PCT_MAX) ? PCT_MAX : r_bright;
    assign pct_255    = {pct_sat, 8'd0} - {8'd0, pct_sat};
    assign scale_prod = 29'(pct_255) * 29'(SCALE_RECIP);

    always_ff @(posedge i_clk) begin
        r_scale <= scale_prod[27:20];
    end

    // Latched input word.
    logic [OP_W-1:0]    r_op;
    logic [INDEX_W-1:0] r_led_index;
    logic [COLOR_W-1:0] r_color;
    logic               r_side;
    logic [STATUS_W-1:0] r_item_status;
    logic               r_item_done;
    logic               in_range;
    logic               tick_done;

    assign in_range = ({1'b0, r_led_index} < 9'(LED_COUNT));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op        <= i_op;
            r_led_index <= i_led_index;
            r_color     <= i_color;
            r_side      <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_status <= ST_OK;
            r_item_done   <= 1'b0;
        end else if (i_cmd.load_item) begin
            r_item_status <= ST_OK;
            r_item_done   <= 1'b0;
        end else if (i_cmd.exec_pixel && !in_range) begin
            r_item_status <= ST_BAD_INDEX;
        end else if (i_cmd.refuse) begin
            r_item_status <= ST_BUSY;
        end else if (i_cmd.tick && tick_done) begin
            r_item_done <= 1'b1;
        end
    end

    // Row counter shared by the half fill and the snapshot.
    logic [LED_W-1:0] r_row, r_row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_row_end <= '0;
        end else if (i_cmd.side_init) begin
            r_row     <= r_side ? LEFT_FIRST : '0;
            r_row_end <= r_side ? LEFT_LAST : RIGHT_LAST;
        end else if (i_cmd.snap_init) begin
            r_row     <= '0;
            r_row_end <= LED_LAST;
        end else if (i_cmd.side_step || i_cmd.snap_step) begin
            r_row <= r_row + 1'b1;
        end
    end

    // Pixel store: one G,R,B row per LED, with a valid bit per row.
    logic [ROW_W-1:0]     pix_mem [LED_COUNT];
    logic [LED_COUNT-1:0] r_valid;
    logic                 pix_we;
    logic [LED_W-1:0]     pix_waddr;
    logic [ROW_W-1:0]     pix_wdata;
    logic [ROW_W-1:0]     r_pix_rdata;
    logic                 r_pix_rvalid;

    assign pix_we    = (i_cmd.exec_pixel && in_range) || i_cmd.side_step;
    assign pix_waddr = i_cmd.exec_pixel ? r_led_index[LED_W-1:0] : r_row;
    assign pix_wdata = {r_color[15:8], r_color[23:16], r_color[7:0]};

    always_ff @(posedge i_clk) begin
        if (pix_we) begin
            pix_mem[pix_waddr] <= pix_wdata;
        end
        r_pix_rdata <= pix_mem[r_row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_pix_rvalid <= 1'b0;
        end else begin
            r_pix_rvalid <= r_valid[r_row];
            if (i_cmd.clear) begin
                r_valid <= '0;
            end else if (pix_we) begin
                r_valid[pix_waddr] <= 1'b1;
            end
        end
    end

    // Snapshot write stage: scale the row read in the previous cycle.
    logic [ROW_W-1:0] pix_row;
    logic [ROW_W-1:0] scaled_row;
    logic             r_wr_pend;
    logic [LED_W-1:0] r_wr_row;

    assign pix_row = r_pix_rvalid ? r_pix_rdata : '0;

    for (genvar b = 0; b < BYTES_PER_LED; b++) begin : g_lane
        assign scaled_row[8*b +: 8] = scale_byte(pix_row[8*b +: 8], r_scale);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= i_cmd.snap_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_row <= r_row;
    end

    // Transmit store; the read port always fetches the next row to be sent.
    logic [ROW_W-1:0] tx_mem [LED_COUNT];
    logic [ROW_W-1:0] r_tx_rdata;
    logic [LED_W-1:0] tx_raddr;

    logic             r_sending, n_sending;
    logic             r_in_latch, n_in_latch;
    logic             r_in_high, n_in_high;
    logic [11:0]      r_ticks, n_ticks;
    logic [LED_W-1:0] r_led_pos, n_led_pos;
    logic [BIT_W-1:0] r_bit_cnt, n_bit_cnt;
    logic [ROW_W-1:0] r_tx_word, n_tx_word;

    assign tx_raddr = (r_in_latch || (r_led_pos == LED_LAST)) ? '0 : r_led_pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (r_wr_pend) begin
            tx_mem[r_wr_row] <= scaled_row;
        end
        r_tx_rdata <= tx_mem[tx_raddr];
    end

    // Phase lengths for a given data bit.
    logic [11:0] hi_rdata, hi_next, lo_cur;

    assign hi_rdata = at_least_one(12'(r_tx_rdata[ROW_W-1] ? r_one_high : r_zero_high));
    assign hi_next  = at_least_one(12'(r_tx_word[ROW_W-2] ? r_one_high : r_zero_high));
    assign lo_cur   = at_least_one(12'(r_tx_word[ROW_W-1] ? r_one_low : r_zero_low));

    // Serializer: latch pause, then high and low phase of every bit.
    always_comb begin
        n_sending  = r_sending;
        n_in_latch = r_in_latch;
        n_in_high  = r_in_high;
        n_ticks    = r_ticks;
        n_led_pos  = r_led_pos;
        n_bit_cnt  = r_bit_cnt;
        n_tx_word  = r_tx_word;
        tick_done  = 1'b0;
        if (i_cmd.frame_start) begin
            n_sending  = 1'b1;
            n_in_latch = 1'b1;
            n_in_high  = 1'b0;
            n_ticks    = at_least_one(r_latch);
        end else if (i_cmd.tick && r_sending) begin
            if (r_ticks > 12'd1) begin
                n_ticks = r_ticks - 12'd1;
            end else if (r_in_latch) begin
                n_in_latch = 1'b0;
                n_led_pos  = '0;
                n_bit_cnt  = '0;
                n_tx_word  = r_tx_rdata;
                n_in_high  = 1'b1;
                n_ticks    = hi_rdata;
            end else if (r_in_high) begin
                n_in_high = 1'b0;
                n_ticks   = lo_cur;
            end else if (r_bit_cnt == BIT_LAST) begin
                if (r_led_pos == LED_LAST) begin
                    n_sending = 1'b0;
                    n_ticks   = '0;
                    n_led_pos = '0;
                    n_bit_cnt = '0;
                    tick_done = 1'b1;
                end else begin
                    n_led_pos = r_led_pos + 1'b1;
                    n_bit_cnt = '0;
                    n_tx_word = r_tx_rdata;
                    n_in_high = 1'b1;
                    n_ticks   = hi_rdata;
                end
            end else begin
                n_bit_cnt = r_bit_cnt + 1'b1;
                n_tx_word = {r_tx_word[ROW_W-2:0], 1'b0};
                n_in_high = 1'b1;
                n_ticks   = hi_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending  <= 1'b0;
            r_in_latch <= 1'b0;
            r_in_high  <= 1'b0;
            r_ticks    <= '0;
            r_led_pos  <= '0;
            r_bit_cnt  <= '0;
        end else begin
            r_sending  <= n_sending;
            r_in_latch <= n_in_latch;
            r_in_high  <= n_in_high;
            r_ticks    <= n_ticks;
            r_led_pos  <= n_led_pos;
            r_bit_cnt  <= n_bit_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tx_word <= n_tx_word;
    end

    // Result word register.
    logic                r_o_line, r_o_busy, r_o_done;
    logic [STATUS_W-1:0] r_o_status;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_line   <= r_sending && !r_in_latch && r_in_high;
            r_o_busy   <= r_sending;
            r_o_done   <= r_item_done;
            r_o_status <= r_item_status;
        end
    end

    assign o_line       = r_o_line;
    assign o_busy_res   = r_o_busy;
    assign o_frame_done = r_o_done;
    assign o_status     = r_o_status;

    assign o_stat.op       = r_op;
    assign o_stat.sending  = r_sending;
    assign o_stat.row_last = (r_row == r_row_end);

endmodule

`default_nettype wire

FILE: rtl/core/rgb_led_strip_serializer_unit.sv
// Serializer for a one-wire addressable RGB LED chain in G,R,B byte order.
// Operation words arrive on i_item (valid/ready): set one pixel, fill the
// right or left half of the chain, clear the pixel store, start a frame, or
// advance one line tick. Every word yields exactly one result word on
// o_result (valid/ready) with the line level, the busy flag, the frame end
// flag and a status code.
// An accepted word passes through the execute and finish states; a half fill
// adds a row step per LED of the half, and a frame start one per LED of the
// chain plus a drain state, set by the single write port of the pixel and
// transmit stores, one LED row per cycle. A result waits in an output
// register, so the next word is accepted while the receiver stalls; a
// further result then waits until that one is taken. The user writes
// configuration registers through i_cfg_we, i_cfg_idx and i_cfg_wdata while
// the block is idle; the block does not enforce it. Synchronous reset clears
// the pixel store at once, stops any frame and restores the default timing.
`default_nettype none

module rgb_led_strip_serializer_unit import rls_pkg::*; #(
    parameter int LED_COUNT = RLS_LED_COUNT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    rls_item_if.sink              i_item,
    rls_result_if.source          o_result
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer for each operation word.
    rls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Stores, scaling and the bit serializer.
    rls_dp #(
        .LED_COUNT (LED_COUNT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_op         (i_item.op),
        .i_led_index  (i_item.led_index),
        .i_color      (i_item.color),
        .i_side       (i_item.side),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_line       (o_result.line),
        .o_busy_res   (o_result.busy_res),
        .o_frame_done (o_result.frame_done),
        .o_status     (o_result.status)
    );

    // A finished frame is never reported as still busy.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.frame_done |-> !o_result.busy_res)
        else $error("frame end reported while busy");

    // A refused start only happens during a frame.
    a_refuse_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && (o_result.status == ST_BUSY) |-> o_result.busy_res)
        else $error("start refused while idle");

    // The line is only driven high inside a frame.
    a_line_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.line |-> o_result.busy_res)
        else $error("line high outside a frame");

    // One word at a time: no accept in the cycle after an accept.
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> !i_item.ready)
        else $error("word accepted while busy");

endmodule

`default_nettype wire

FILE: test/rgb_led_strip_serializer_unit_tb.sv
`default_nettype none

module rgb_led_strip_serializer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rls_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 9;
    localparam int IDLE_MAX      = 18;
    localparam int SETTLE_CYCLES = 20;
    localparam int LIMIT_CYCLES  = 3_000_000;
    localparam int STORE_BYTES   = RLS_LED_COUNT * BYTES_PER_LED;
    localparam int HALF_LEDS     = RLS_LED_COUNT / 2;
    localparam int PERCENT_MAX   = 127;
    localparam int FRAME_LATCH   = 3;
    localparam int EARLY_TICKS   = 40;
    localparam int TAIL_WORDS    = 24;

    // Op codes the block does not use.
    localparam logic [OP_W-1:0] OP_SPARE_LO = OP_TICK + 3'd1;
    localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

    typedef struct packed {
        logic                line;
        logic                busy;
        logic                done;
        logic [STATUS_W-1:0] status;
    } t_line_status;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    bit                    idle_on   = 1'b1;
    int                    fail_count = 0;

    rls_item_if   item_if();
    rls_result_if result_if();

    rgb_led_strip_serializer_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_if),
        .o_result    (result_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Shadow copy of the registers and the strip state.
    logic [6:0]  bright_pct;
    logic [5:0]  zero_high;
    logic [5:0]  zero_low;
    logic [5:0]  one_high;
    logic [5:0]  one_low;
    logic [11:0] latch_len;
    logic [7:0]  pix_bytes [STORE_BYTES];
    logic [7:0]  xmit_bytes [STORE_BYTES];
    bit          frame_on;
    bit          in_latch;
    bit          in_high;
    int unsigned byte_pos;
    int unsigned bit_pos;
    int unsigned ticks_left;

    t_line_status line_status_q[$];

    task automatic reset_strip_model();
        bright_pct = 7'd100;
        zero_high  = 6'd3;
        zero_low   = 6'd9;
        one_high   = 6'd6;
        one_low    = 6'd6;
        latch_len  = 12'd800;
        foreach (pix_bytes[i]) pix_bytes[i] = '0;
        foreach (xmit_bytes[i]) xmit_bytes[i] = '0;
        frame_on   = 1'b0;
        in_latch   = 1'b0;
        in_high    = 1'b0;
        byte_pos   = 0;
        bit_pos    = 0;
        ticks_left = 0;
    endtask

    function automatic int unsigned min_one(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    // Brightness scaling with the video-safe round-up.
    function automatic logic [7:0] dim_byte(logic [7:0] v);
        int unsigned pct;
        int unsigned scale;
        int unsigned prod;
        pct   = (bright_pct > 7'd100) ? 100 : 32'(bright_pct);
        scale = (pct * 255) / 100;
        prod  = ((32'(v) * scale) >> 8) + ((v != 0 && scale != 0) ? 1 : 0);
        return prod[7:0];
    endfunction

    function automatic bit bit_now();
        if (byte_pos >= STORE_BYTES) return 1'b0;
        return xmit_bytes[byte_pos][7 - bit_pos];
    endfunction

    task automatic put_led(int unsigned led, logic [COLOR_W-1:0] color);
        int unsigned base;
        base = led * BYTES_PER_LED;
        if (base + 2 >= STORE_BYTES) return;
        pix_bytes[base]     = color[15:8];
        pix_bytes[base + 1] = color[23:16];
        pix_bytes[base + 2] = color[7:0];
    endtask

    task automatic load_high_part();
        in_high    = 1'b1;
        ticks_left = min_one(bit_now() ? 32'(one_high) : 32'(zero_high));
    endtask

    // One line tick: latch pause, then high and low part of each bit.
    task automatic step_tick(output bit done);
        done = 1'b0;
        if (!frame_on) return;
        if (ticks_left > 0) ticks_left--;
        if (ticks_left != 0) return;
        if (in_latch) begin
            in_latch = 1'b0;
            byte_pos = 0;
            bit_pos  = 0;
            load_high_part();
            return;
        end
        if (in_high) begin
            in_high    = 1'b0;
            ticks_left = min_one(bit_now() ? 32'(one_low) : 32'(zero_low));
            return;
        end
        if (bit_pos == 7) begin
            bit_pos = 0;
            byte_pos++;
        end else begin
            bit_pos++;
        end
        if (byte_pos >= STORE_BYTES) begin
            frame_on   = 1'b0;
            byte_pos   = 0;
            bit_pos    = 0;
            ticks_left = 0;
            done       = 1'b1;
            return;
        end
        load_high_part();
    endtask

    // Applies one accepted word to the shadow state and queues its result.
    task automatic serialize_word(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] led,
                                  input logic [COLOR_W-1:0] color, input logic side);
        t_line_status res;
        int unsigned  first;
        bit           done;
        res  = '0;
        done = 1'b0;
        case (op)
            OP_SET_PIXEL: begin
                if (32'(led) >= RLS_LED_COUNT) res.status = ST_BAD_INDEX;
                else put_led(32'(led), color);
            end
            OP_SET_SIDE: begin
                first = side ? HALF_LEDS : 0;
                for (int unsigned i = first; i < first + HALF_LEDS; i++) put_led(i, color);
            end
            OP_CLEAR: begin
                foreach (pix_bytes[i]) pix_bytes[i] = '0;
            end
            OP_START: begin
                if (frame_on) begin
                    res.status = ST_BUSY;
                end else begin
                    foreach (xmit_bytes[i]) xmit_bytes[i] = dim_byte(pix_bytes[i]);
                    frame_on   = 1'b1;
                    in_latch   = 1'b1;
                    in_high    = 1'b0;
                    byte_pos   = 0;
                    bit_pos    = 0;
                    ticks_left = min_one(32'(latch_len));
                end
            end
            OP_TICK: begin
                step_tick(done);
            end
            default: begin
            end
        endcase
        res.line = frame_on && !in_latch && in_high;
        res.busy = frame_on;
        res.done = done;
        line_status_q.push_back(res);
    endtask

    // Sends one word, with an occasional random gap in front of it.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] led,
                             input logic [COLOR_W-1:0] color, input logic side);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, IDLE_MAX)) @(posedge clk);
        end
        item_if.valid     <= 1'b1;
        item_if.op        <= op;
        item_if.led_index <= led;
        item_if.color     <= color;
        item_if.side      <= side;
        @(posedge clk);
        while (!item_if.ready) @(posedge clk);
        serialize_word(op, led, color, side);
    endtask

    task automatic send_tick();
        send_word(OP_TICK, INDEX_W'($urandom), COLOR_W'($urandom), 1'($urandom));
    endtask

    // Any kind of word, weighted toward pixel edits.
    task automatic send_random_word();
        int unsigned        pick;
        logic [INDEX_W-1:0] led;
        logic [COLOR_W-1:0] color;
        logic               side;
        pick  = $urandom_range(0, 99);
        color = COLOR_W'($urandom);
        side  = 1'($urandom);
        if ($urandom_range(0, 9) == 0) led = INDEX_W'($urandom);
        else led = INDEX_W'($urandom_range(0, RLS_LED_COUNT - 1));
        if (pick < 50) send_word(OP_SET_PIXEL, led, color, side);
        else if (pick < 65) send_word(OP_SET_SIDE, led, color, side);
        else if (pick < 70) send_word(OP_CLEAR, led, color, side);
        else if (pick < 78) send_word(OP_START, led, color, side);
        else if (pick < 92) send_tick();
        else send_word(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), led, color, side);
    endtask

    // Ticks until the frame ends, mixing in other words at the given percentage.
    task automatic finish_frame(int unsigned mix_pct);
        while (frame_on) begin
            if ($urandom_range(0, 99) < mix_pct) send_random_word();
            else send_tick();
        end
    endtask

    // Waits until every queued result has come back and the block has gone quiet.
    task automatic settle_block();
        item_if.valid <= 1'b0;
        while (line_status_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        settle_block();
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_BRIGHTNESS: bright_pct = data[6:0];
            CFG_ZERO_HIGH:  zero_high  = data[5:0];
            CFG_ZERO_LOW:   zero_low   = data[5:0];
            CFG_ONE_HIGH:   one_high   = data[5:0];
            CFG_ONE_LOW:    one_low    = data[5:0];
            CFG_LATCH:      latch_len  = data[11:0];
            default: begin
            end
        endcase
    endtask

    task automatic write_bit_timing(int unsigned zh, int unsigned zl, int unsigned oh,
                                    int unsigned ol);
        write_reg(CFG_ZERO_HIGH, zh);
        write_reg(CFG_ZERO_LOW, zl);
        write_reg(CFG_ONE_HIGH, oh);
        write_reg(CFG_ONE_LOW, ol);
    endtask

    // Edits and idle-line behavior with the reset settings.
    task automatic test_idle_edits();
        send_tick();
        for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++) begin
            send_word(OP_W'(op), '1, '1, 1'b1);
        end
        send_word(OP_SET_PIXEL, '0, 24'hFFFFFF, 1'b0);
        send_word(OP_SET_PIXEL, INDEX_W'(RLS_LED_COUNT - 1), 24'h000001, 1'b1);
        send_word(OP_SET_PIXEL, INDEX_W'(RLS_LED_COUNT), 24'h123456, 1'b0);
        send_word(OP_SET_PIXEL, '1, 24'hFFFFFF, 1'b1);
        send_word(OP_SET_SIDE, '0, 24'h123456, 1'b0);
        send_word(OP_SET_SIDE, '1, 24'hA5C30F, 1'b1);
        send_word(OP_CLEAR, '0, '0, 1'b0);
        send_word(OP_SET_PIXEL, INDEX_W'(3), 24'h8001FE, 1'b0);
        send_word(OP_SET_SIDE, '0, 24'h000000, 1'b1);
        send_tick();
    endtask

    // A whole frame at saturated brightness: refused start, edits and timing changes
    // mid-frame, the frame end, then a tick on the idle line.
    task automatic test_full_frame();
        write_reg(CFG_BRIGHTNESS, PERCENT_MAX);
        write_reg(CFG_LATCH, FRAME_LATCH);
        write_bit_timing(0, 1, 2, 0);
        send_word(OP_SET_PIXEL, '0, 24'h55AA33, 1'b0);
        send_word(OP_SET_PIXEL, INDEX_W'(1), 24'hFF00FF, 1'b0);
        send_word(OP_START, '0, '0, 1'b0);
        send_word(OP_START, '1, '1, 1'b1);
        send_word(OP_SET_PIXEL, '0, 24'h000000, 1'b0);
        send_word(OP_SET_SIDE, '0, 24'hFFFFFF, 1'b1);
        send_word(OP_CLEAR, '0, '0, 1'b0);
        repeat (EARLY_TICKS) send_tick();
        // New bit times only take hold at the next phase boundary.
        write_bit_timing(1, 0, 1, 2);
        write_reg(CFG_LATCH, 0);
        finish_frame(2);
        send_tick();
    endtask

    // Random settings and edits, then the opening of one more frame with words
    // mixed in; the receiver and the sender no longer pause here.
    task automatic test_random_frames();
        int unsigned pct;
        idle_on = 1'b0;
        case ($urandom_range(0, 3))
            0: pct = 0;
            1: pct = 100;
            2: pct = $urandom_range(101, PERCENT_MAX);
            default: pct = $urandom_range(1, 99);
        endcase
        write_reg(CFG_BRIGHTNESS, pct);
        write_reg(CFG_LATCH, $urandom_range(0, 15));
        write_bit_timing($urandom_range(0, 2), $urandom_range(0, 2),
                         $urandom_range(0, 2), $urandom_range(0, 2));
        repeat ($urandom_range(8, 16)) send_random_word();
        send_word(OP_START, INDEX_W'($urandom), COLOR_W'($urandom), 1'($urandom));
        repeat (TAIL_WORDS) begin
            if ($urandom_range(0, 99) < 20) send_random_word();
            else send_tick();
        end
    endtask

    // Receiver: ready with random stall bursts.
    initial begin
        result_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, IDLE_MAX)) @(posedge clk);
            end
            result_if.ready <= 1'b1;
        end
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Compare each accepted result word with the oldest queued one.
    always @(posedge clk) begin : check_result
        t_line_status want;
        if (rst_n && result_if.valid && result_if.ready) begin
            if (line_status_q.size() == 0) begin
                $error("result word arrived with none pending");
                fail_count++;
            end else begin
                want = line_status_q.pop_front();
                check_field("line", 32'(want.line), 32'(result_if.line));
                check_field("busy_res", 32'(want.busy), 32'(result_if.busy_res));
                check_field("frame_done", 32'(want.done), 32'(result_if.frame_done));
                check_field("status", 32'(want.status), 32'(result_if.status));
            end
        end
    end

    initial begin
        item_if.valid     = 1'b0;
        item_if.op        = OP_TICK;
        item_if.led_index = '0;
        item_if.color     = '0;
        item_if.side      = 1'b0;
        reset_strip_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_edits();
        test_full_frame();
        test_random_frames();
        settle_block();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
